@@ sv/jsct_pkg.sv @@
// ============================================================================
// jsct_pkg: shared types and constants for the joystick scale/calibrate block
// Holds the item structs seen on the ports, the internal command word that
// travels from the front end to the back end, and the channel numbering.
// ============================================================================
package jsct_pkg;

    localparam int NUM_CH = 4;

    // Channel numbering inside the command and bias arrays.
    localparam logic [1:0] CH_THR = 2'd0;
    localparam logic [1:0] CH_YAW = 2'd1;
    localparam logic [1:0] CH_PIT = 2'd2;
    localparam logic [1:0] CH_ROL = 2'd3;

    localparam int LEVEL_W = 10;
    localparam int BIAS_W  = 11;
    localparam int ACC_W   = 18;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1000;

    // Input opcode values.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_KEY    = 1'b1;

    // The four arrow keys are named after the trim they apply.
    typedef enum logic [2:0] {
        KEY_NONE      = 3'd0,
        KEY_CAL       = 3'd1,
        KEY_FIX       = 3'd2,
        KEY_PWR       = 3'd3,
        KEY_ROLL_INC  = 3'd4,
        KEY_ROLL_DEC  = 3'd5,
        KEY_PITCH_DEC = 3'd6,
        KEY_PITCH_INC = 3'd7
    } key_t;

    typedef enum logic [2:0] {
        CMD_NOP    = 3'd0,
        CMD_SAMPLE = 3'd1,
        CMD_CAL    = 3'd2,
        CMD_FIX    = 3'd3,
        CMD_PWR    = 3'd4,
        CMD_TRIM   = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        logic        opcode;
        logic [11:0] throttle_raw;
        logic [11:0] yaw_raw;
        logic [11:0] pitch_raw;
        logic [11:0] roll_raw;
        logic [2:0]  key_code;
    } in_item_t;

    typedef struct packed {
        logic [9:0] throttle_out;
        logic [9:0] yaw_out;
        logic [9:0] pitch_out;
        logic [9:0] roll_out;
        logic       fixed_height;
        logic       power_down;
    } out_item_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t                       kind;
        logic                            trim_pitch;
        logic                            trim_neg;
        logic [NUM_CH-1:0][LEVEL_W-1:0]  level;
    } cmd_t;

endpackage

@@ sv/jsct_fifo.sv @@
// ============================================================================
// jsct_fifo: small synchronous queue
// Register-based first-in first-out queue with full and empty flags.
// DEPTH must be a power of two so that the pointers wrap on their own.
// ============================================================================
module jsct_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/jsct_front.sv @@
// ============================================================================
// jsct_front: input classification and channel scaling
// Decodes each accepted item into a command and scales the four readings
// from 0..4095 to 0..1000, inverting yaw.
// ============================================================================
module jsct_front (
    input  logic                push,
    input  jsct_pkg::in_item_t  item,
    input  logic                mid_full,
    output logic                mid_push,
    output jsct_pkg::cmd_t      cmd
);

    // raw * 1000 / 4095, truncated. The quotient estimate
    // (p + p/4096) / 4096 is low by at most one; one compare fixes it.
    function automatic logic [9:0] scale_raw(input logic [11:0] raw);
        logic [21:0] prod;
        logic [22:0] est;
        logic [9:0]  q0;
        logic [21:0] rem_w;
        logic [12:0] rem;
        prod  = 22'(raw) * 22'd1000;
        est   = {1'b0, prod} + 23'(prod[21:12]);
        q0    = est[21:12];
        rem_w = prod - {q0, 12'b0} + 22'(q0);
        rem   = rem_w[12:0];
        return (rem >= 13'd4095) ? q0 + 10'd1 : q0;
    endfunction

    logic accept;

    assign accept   = push && !mid_full;
    assign mid_push = accept && (cmd.kind != jsct_pkg::CMD_NOP);

    always_comb
    begin
        cmd.kind       = jsct_pkg::CMD_NOP;
        cmd.trim_pitch = 1'b0;
        cmd.trim_neg   = 1'b0;
        cmd.level[jsct_pkg::CH_THR] = scale_raw(item.throttle_raw);
        cmd.level[jsct_pkg::CH_YAW] = jsct_pkg::LEVEL_MAX - scale_raw(item.yaw_raw);
        cmd.level[jsct_pkg::CH_PIT] = scale_raw(item.pitch_raw);
        cmd.level[jsct_pkg::CH_ROL] = scale_raw(item.roll_raw);

        if (item.opcode == jsct_pkg::OP_SAMPLE)
        begin
            cmd.kind = jsct_pkg::CMD_SAMPLE;
        end
        else
        begin
            unique case (jsct_pkg::key_t'(item.key_code))
                jsct_pkg::KEY_NONE:  cmd.kind = jsct_pkg::CMD_NOP;
                jsct_pkg::KEY_CAL:   cmd.kind = jsct_pkg::CMD_CAL;
                jsct_pkg::KEY_FIX:   cmd.kind = jsct_pkg::CMD_FIX;
                jsct_pkg::KEY_PWR:   cmd.kind = jsct_pkg::CMD_PWR;
                jsct_pkg::KEY_ROLL_INC:
                begin
                    cmd.kind = jsct_pkg::CMD_TRIM;
                end
                jsct_pkg::KEY_ROLL_DEC:
                begin
                    cmd.kind     = jsct_pkg::CMD_TRIM;
                    cmd.trim_neg = 1'b1;
                end
                jsct_pkg::KEY_PITCH_DEC:
                begin
                    cmd.kind       = jsct_pkg::CMD_TRIM;
                    cmd.trim_pitch = 1'b1;
                    cmd.trim_neg   = 1'b1;
                end
                jsct_pkg::KEY_PITCH_INC:
                begin
                    cmd.kind       = jsct_pkg::CMD_TRIM;
                    cmd.trim_pitch = 1'b1;
                end
                default:             cmd.kind = jsct_pkg::CMD_NOP;
            endcase
        end
    end

endmodule

@@ sv/jsct_back.sv @@
// ============================================================================
// jsct_back: bias state, calibration and output correction
// Executes queued commands in order: bias trims, sticky flags, calibration
// averaging, and the bias-corrected, clamped result for each stick sample.
// ============================================================================
module jsct_back #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jsct_pkg::cmd_t       cmd,
    input  logic                 mid_empty,
    output logic                 mid_pop,
    input  logic                 out_full,
    output logic                 out_push,
    output jsct_pkg::out_item_t  out_data
);

    localparam int BW      = jsct_pkg::BIAS_W;
    localparam int AW      = jsct_pkg::ACC_W;
    localparam int MAG_W   = AW - 1;
    localparam int DIV_LOG = $clog2(CAL_SAMPLES);
    localparam int DIV_SH  = MAG_W + DIV_LOG;
    localparam int MULT_W  = MAG_W + 1;
    localparam int PROD_W  = MAG_W + MULT_W;
    // Rounded-up reciprocal; exact for every magnitude below 2**MAG_W.
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [7:0] CAL_N = 8'(CAL_SAMPLES);

    localparam logic signed [BW-1:0] BIAS_LIM  = 11'sd1000;
    localparam logic signed [BW:0]   TRIM_STEP = 12'sd10;
    localparam logic signed [BW-1:0] CENTER    = 11'sd500;

    logic signed [BW-1:0] bias_reg [jsct_pkg::NUM_CH];
    logic signed [BW-1:0] bias_next [jsct_pkg::NUM_CH];
    logic signed [AW-1:0] acc_reg [jsct_pkg::NUM_CH];
    logic signed [AW-1:0] acc_next [jsct_pkg::NUM_CH];
    logic [6:0]           count_reg;
    logic [6:0]           count_next;
    logic                 cal_reg;
    logic                 cal_next;
    logic                 fin_reg;
    logic                 fin_next;
    logic                 fh_reg;
    logic                 fh_next;
    logic                 pd_reg;
    logic                 pd_next;

    logic signed [BW-1:0] quot [jsct_pkg::NUM_CH];
    logic [9:0]           corr [jsct_pkg::NUM_CH];
    logic [1:0]           trim_ch;
    logic signed [BW:0]   trim_sum;
    logic [7:0]           cnt_inc;

    // Average = accumulator / CAL_SAMPLES, truncated toward zero.
    always_comb
    begin
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [BW-1:0]     qmag;
        for (int ch = 0; ch < jsct_pkg::NUM_CH; ch++)
        begin
            mag      = acc_reg[ch][AW-1] ? MAG_W'(-acc_reg[ch]) : MAG_W'(acc_reg[ch]);
            prod     = PROD_W'(mag) * PROD_W'(DIV_MULT);
            qmag     = prod[DIV_SH +: BW];
            quot[ch] = acc_reg[ch][AW-1] ? -$signed(qmag) : $signed(qmag);
        end
    end

    // Bias-corrected level, clamped to 0..1000.
    always_comb
    begin
        logic signed [BW:0] diff;
        for (int ch = 0; ch < jsct_pkg::NUM_CH; ch++)
        begin
            diff = $signed({2'b00, cmd.level[ch]}) - $signed({bias_reg[ch][BW-1], bias_reg[ch]});
            if (diff < 0)
            begin
                corr[ch] = '0;
            end
            else if (diff > $signed({2'b00, jsct_pkg::LEVEL_MAX}))
            begin
                corr[ch] = jsct_pkg::LEVEL_MAX;
            end
            else
            begin
                corr[ch] = diff[9:0];
            end
        end
    end

    assign trim_ch  = cmd.trim_pitch ? jsct_pkg::CH_PIT : jsct_pkg::CH_ROL;
    assign trim_sum = cmd.trim_neg
                    ? $signed({bias_reg[trim_ch][BW-1], bias_reg[trim_ch]}) - TRIM_STEP
                    : $signed({bias_reg[trim_ch][BW-1], bias_reg[trim_ch]}) + TRIM_STEP;
    assign cnt_inc  = {1'b0, count_reg} + 8'd1;

    assign mid_pop = !mid_empty && !fin_reg && !out_full;

    assign out_data.throttle_out = corr[jsct_pkg::CH_THR];
    assign out_data.yaw_out      = corr[jsct_pkg::CH_YAW];
    assign out_data.pitch_out    = corr[jsct_pkg::CH_PIT];
    assign out_data.roll_out     = corr[jsct_pkg::CH_ROL];
    assign out_data.fixed_height = fh_reg;
    assign out_data.power_down   = pd_reg;

    always_comb
    begin
        bias_next  = bias_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        cal_next   = cal_reg;
        fin_next   = fin_reg;
        fh_next    = fh_reg;
        pd_next    = pd_reg;
        out_push   = 1'b0;

        if (fin_reg)
        begin
            // In the cycle after the last calibration sample: load the averages.
            for (int ch = 0; ch < jsct_pkg::NUM_CH; ch++)
            begin
                bias_next[ch] = quot[ch];
            end
            fin_next = 1'b0;
        end
        else if (mid_pop)
        begin
            unique case (cmd.kind)
                jsct_pkg::CMD_CAL:
                begin
                    for (int ch = 0; ch < jsct_pkg::NUM_CH; ch++)
                    begin
                        bias_next[ch] = '0;
                        acc_next[ch]  = '0;
                    end
                    count_next = '0;
                    cal_next   = 1'b1;
                end
                jsct_pkg::CMD_FIX: fh_next = 1'b1;
                jsct_pkg::CMD_PWR: pd_next = 1'b1;
                jsct_pkg::CMD_TRIM:
                begin
                    if (trim_sum > $signed({BIAS_LIM[BW-1], BIAS_LIM}))
                    begin
                        bias_next[trim_ch] = BIAS_LIM;
                    end
                    else if (trim_sum < -$signed({BIAS_LIM[BW-1], BIAS_LIM}))
                    begin
                        bias_next[trim_ch] = -BIAS_LIM;
                    end
                    else
                    begin
                        bias_next[trim_ch] = trim_sum[BW-1:0];
                    end
                end
                jsct_pkg::CMD_SAMPLE:
                begin
                    if (cal_reg)
                    begin
                        for (int ch = 0; ch < jsct_pkg::NUM_CH; ch++)
                        begin
                            if (ch == int'(jsct_pkg::CH_THR))
                            begin
                                acc_next[ch] = acc_reg[ch]
                                             + AW'($signed({1'b0, cmd.level[ch]}));
                            end
                            else
                            begin
                                acc_next[ch] = acc_reg[ch]
                                             + AW'($signed({1'b0, cmd.level[ch]}) - CENTER);
                            end
                        end
                        if (cnt_inc >= CAL_N)
                        begin
                            count_next = '0;
                            cal_next   = 1'b0;
                            fin_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = cnt_inc[6:0];
                        end
                    end
                    else
                    begin
                        out_push = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < jsct_pkg::NUM_CH; ch++)
            begin
                bias_reg[ch] <= '0;
                acc_reg[ch]  <= '0;
            end
            count_reg <= '0;
            cal_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            fh_reg    <= 1'b0;
            pd_reg    <= 1'b0;
        end
        else
        begin
            bias_reg  <= bias_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            cal_reg   <= cal_next;
            fin_reg   <= fin_next;
            fh_reg    <= fh_next;
            pd_reg    <= pd_next;
        end
    end

`ifndef SYNTHESIS
    a_fin_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !mid_pop)
        else $error("command taken during bias load");

    a_fin_ends_cal: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (!cal_reg && count_reg == '0))
        else $error("calibration still active during bias load");

    a_no_result_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (!cal_reg && !fin_reg))
        else $error("result produced during calibration");

    a_roll_bias_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bias_reg[jsct_pkg::CH_ROL] <= BIAS_LIM) && (bias_reg[jsct_pkg::CH_ROL] >= -BIAS_LIM))
        else $error("roll bias outside trim range");

    a_count_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} < CAL_N))
        else $error("calibration count overran");
`endif

endmodule

@@ sv/joystick_scale_calibrate_trim_top.sv @@
// ============================================================================
// joystick_scale_calibrate_trim_top: joystick scaling and offset calibration
// Scales four stick channels to 0..1000, removes per-channel biases, runs
// key-triggered calibration and trims, and keeps two sticky mode flags.
// ============================================================================
// The block takes one item per clock while the command queue is not full:
// either a stick sample with four 12-bit readings or a key event. The front
// end scales every channel to 0..1000 (yaw inverted) and classifies the
// item, writing it into a QUEUE_DEPTH-entry command queue; the back end
// drains that queue one command per cycle unless the result queue is full,
// applying trims, flags and calibration, and writes each result into a
// QUEUE_DEPTH-entry result queue, from which it can be taken. With pop held
// high the block sustains one item per cycle. The exception is the end of a
// calibration: after the CAL_SAMPLES-th calibration sample the back end holds
// the command queue while it divides the four sums by CAL_SAMPLES (a
// reciprocal multiply per channel), and while it does so the command queue
// absorbs incoming items. Key events and samples taken during calibration
// produce no result.
// ============================================================================
module joystick_scale_calibrate_trim_top #(
    parameter int CAL_SAMPLES = 100,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jsct_pkg::in_item_t   item,
    output logic                 full,
    input  logic                 pop,
    output jsct_pkg::out_item_t  result,
    output logic                 empty
);

    // Command path between the two halves.
    jsct_pkg::cmd_t      front_cmd;
    jsct_pkg::cmd_t      back_cmd;
    logic                mid_push;
    logic                mid_full;
    logic                mid_pop;
    logic                mid_empty;

    // Result path into the output queue.
    jsct_pkg::out_item_t back_result;
    logic                out_push;
    logic                out_full;

    // The input side is stalled only by a full command queue.
    assign full = mid_full;

    jsct_front u_front (
        .push     (push),
        .item     (item),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .cmd      (front_cmd)
    );

    jsct_fifo #(
        .W     ($bits(jsct_pkg::cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (front_cmd),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (back_cmd),
        .empty (mid_empty)
    );

    jsct_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (back_result)
    );

    // The result queue decouples the consumer from the back end, so a stalled
    // consumer does not stop the back end until this queue fills.
    jsct_fifo #(
        .W     ($bits(jsct_pkg::out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

@@ tb/tb_joystick_scale_calibrate_trim_top.sv @@
// ============================================================================
// tb_joystick_scale_calibrate_trim_top: self-checking bench for the joystick
// scaling, calibration and trim block
// A queue of stick samples and key events is built up front and fed through
// the push/full side by a clocked driver. Each accepted item runs through a
// behavioral model of scaling, bias removal, calibration, trims and the
// sticky flags. A clocked monitor on the empty/pop side checks every result,
// field by field, against the oldest expected stick level set.
// ============================================================================
module tb_joystick_scale_calibrate_trim_top;

    // The block is built with its default calibration length.
    localparam int CAL_N       = 100;
    localparam int RAW_MAX     = 4095;
    localparam int LEVEL_TOP   = 1000;
    localparam int CENTER      = 500;
    localparam int TRIM_STEP   = 10;
    localparam int TRIM_LIMIT  = 1000;
    localparam int ITEM_TARGET = 1850;
    // Once fewer than this many items remain, neither side idles.
    localparam int CALM_ITEMS  = 150;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed for trailing key events to settle after the last result.
    localparam int TAIL_CYCLES = 16;

    localparam int NUM_CH  = jsct_pkg::NUM_CH;
    localparam int LEVEL_W = jsct_pkg::LEVEL_W;
    localparam int BIAS_W  = jsct_pkg::BIAS_W;
    localparam int ACC_W   = jsct_pkg::ACC_W;

    // One entry of the send queue. A drain_first entry is held back until
    // every stick level set already predicted has come out of the block.
    typedef struct {
        jsct_pkg::in_item_t data;
        bit                 drain_first;
    } pending_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    jsct_pkg::in_item_t  item = '0;
    logic                full;
    logic                pop = 1'b0;
    jsct_pkg::out_item_t result;
    logic                empty;

    joystick_scale_calibrate_trim_top #(
        .CAL_SAMPLES(CAL_N)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .result(result),
        .empty (empty)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Model state: the bench's own copy of the block's biases, calibration
    // sums and flags, advanced once per accepted item.
    // ------------------------------------------------------------------------
    logic signed [BIAS_W-1:0] model_bias [NUM_CH];
    logic signed [ACC_W-1:0]  model_sum [NUM_CH];
    logic [6:0]               model_cal_count = '0;
    bit                       model_calibrating = 1'b0;
    bit                       model_fix = 1'b0;
    bit                       model_pwr = 1'b0;

    pending_item_t       items_to_send [$];
    jsct_pkg::out_item_t stick_levels_due [$];

    int mismatches = 0;
    int results_checked = 0;
    int items_sent = 0;
    int calibrations_done = 0;
    int trims_saturated = 0;
    int send_gap = 0;
    int pop_gap = 0;
    int send_idle_pct = 15;
    int pop_idle_pct = 15;
    int quiet_cycles = 0;
    bit timed_out = 1'b0;

    initial
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            model_bias[ch] = '0;
            model_sum[ch] = '0;
        end
    end

    // Converter reading to 0..1000, truncated.
    function automatic int scale_level(input logic [11:0] raw);
        return (int'(raw) * LEVEL_TOP) / RAW_MAX;
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
        if (v < 0)
            return '0;
        if (v > LEVEL_TOP)
            return jsct_pkg::LEVEL_MAX;
        return v[LEVEL_W-1:0];
    endfunction

    // Arrow keys move a bias by one step; the bias saturates at the limits.
    function automatic void trim_bias(input logic [1:0] ch, input int delta);
        int v;
        v = int'(model_bias[ch]) + delta;
        if (v > TRIM_LIMIT || v < -TRIM_LIMIT)
        begin
            trims_saturated++;
            v = (v > 0) ? TRIM_LIMIT : -TRIM_LIMIT;
        end
        model_bias[ch] = v[BIAS_W-1:0];
    endfunction

    // Advances the model by one accepted item. Returns 1 and the expected
    // stick levels when the item is a sample taken outside calibration.
    function automatic bit apply_stick_item(input jsct_pkg::in_item_t it,
                                            output jsct_pkg::out_item_t lv);
        int level [NUM_CH];
        int rest;
        lv = '0;
        if (it.opcode == jsct_pkg::OP_KEY)
        begin
            case (jsct_pkg::key_t'(it.key_code))
                jsct_pkg::KEY_CAL:
                begin
                    // Restarts cleanly even when a calibration is running.
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        model_bias[ch] = '0;
                        model_sum[ch] = '0;
                    end
                    model_cal_count = '0;
                    model_calibrating = 1'b1;
                end
                jsct_pkg::KEY_FIX:       model_fix = 1'b1;
                jsct_pkg::KEY_PWR:       model_pwr = 1'b1;
                jsct_pkg::KEY_ROLL_INC:  trim_bias(jsct_pkg::CH_ROL, TRIM_STEP);
                jsct_pkg::KEY_ROLL_DEC:  trim_bias(jsct_pkg::CH_ROL, -TRIM_STEP);
                jsct_pkg::KEY_PITCH_DEC: trim_bias(jsct_pkg::CH_PIT, -TRIM_STEP);
                jsct_pkg::KEY_PITCH_INC: trim_bias(jsct_pkg::CH_PIT, TRIM_STEP);
                default:                 ;
            endcase
            return 1'b0;
        end

        level[jsct_pkg::CH_THR] = scale_level(it.throttle_raw);
        level[jsct_pkg::CH_YAW] = LEVEL_TOP - scale_level(it.yaw_raw);
        level[jsct_pkg::CH_PIT] = scale_level(it.pitch_raw);
        level[jsct_pkg::CH_ROL] = scale_level(it.roll_raw);

        if (model_calibrating)
        begin
            // Throttle rests at zero, the other sticks at center.
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                rest = (ch == int'(jsct_pkg::CH_THR)) ? 0 : CENTER;
                model_sum[ch] = ACC_W'(int'(model_sum[ch]) + level[ch] - rest);
            end
            model_cal_count = model_cal_count + 7'd1;
            if (int'(model_cal_count) >= CAL_N)
            begin
                // Signed division truncates toward zero, and the average
                // overwrites any trim made during the calibration.
                for (int ch = 0; ch < NUM_CH; ch++)
                    model_bias[ch] = BIAS_W'(int'(model_sum[ch]) / CAL_N);
                model_calibrating = 1'b0;
                model_cal_count = '0;
                calibrations_done++;
            end
            return 1'b0;
        end

        lv.throttle_out = clamp_level(level[jsct_pkg::CH_THR]
                                      - int'(model_bias[jsct_pkg::CH_THR]));
        lv.yaw_out      = clamp_level(level[jsct_pkg::CH_YAW]
                                      - int'(model_bias[jsct_pkg::CH_YAW]));
        lv.pitch_out    = clamp_level(level[jsct_pkg::CH_PIT]
                                      - int'(model_bias[jsct_pkg::CH_PIT]));
        lv.roll_out     = clamp_level(level[jsct_pkg::CH_ROL]
                                      - int'(model_bias[jsct_pkg::CH_ROL]));
        lv.fixed_height = model_fix;
        lv.power_down   = model_pwr;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (after %0d results)",
                 what, got, want, results_checked);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers. Fields that an item ignores still carry random bits.
    // ------------------------------------------------------------------------
    function automatic logic [11:0] pick_raw();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 12'(RAW_MAX);
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic queue_sample(input logic [11:0] thr, input logic [11:0] yaw,
                                input logic [11:0] pit, input logic [11:0] rol,
                                input bit drain = 1'b0);
        pending_item_t p;
        p.data.opcode       = jsct_pkg::OP_SAMPLE;
        p.data.throttle_raw = thr;
        p.data.yaw_raw      = yaw;
        p.data.pitch_raw    = pit;
        p.data.roll_raw     = rol;
        p.data.key_code     = 3'($urandom);
        p.drain_first       = drain;
        items_to_send.push_back(p);
    endtask

    task automatic queue_random_sample();
        queue_sample(pick_raw(), pick_raw(), pick_raw(), pick_raw());
    endtask

    task automatic queue_key(input jsct_pkg::key_t k, input bit drain = 1'b0);
        pending_item_t p;
        p.data.opcode       = jsct_pkg::OP_KEY;
        p.data.throttle_raw = 12'($urandom);
        p.data.yaw_raw      = 12'($urandom);
        p.data.pitch_raw    = 12'($urandom);
        p.data.roll_raw     = 12'($urandom);
        p.data.key_code     = k;
        p.drain_first       = drain;
        items_to_send.push_back(p);
    endtask

    function automatic jsct_pkg::key_t pick_trim_key();
        case ($urandom_range(0, 3))
            0:       return jsct_pkg::KEY_ROLL_INC;
            1:       return jsct_pkg::KEY_ROLL_DEC;
            2:       return jsct_pkg::KEY_PITCH_DEC;
            default: return jsct_pkg::KEY_PITCH_INC;
        endcase
    endfunction

    // A reading near the given rest point, kept inside the converter range.
    function automatic logic [11:0] near_raw(input int rest, input int spread);
        int v;
        v = rest + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > RAW_MAX)
            v = RAW_MAX;
        return v[11:0];
    endfunction

    // A full calibration: the key, then CAL_N samples. Some runs are cut
    // short by a second calibrate key, and some carry trims in the middle.
    task automatic queue_calibration();
        int style;
        int restart_at;
        logic [11:0] fixed_raw;
        style = $urandom_range(0, 3);
        fixed_raw = $urandom_range(0, 1) ? 12'(RAW_MAX) : 12'd0;
        restart_at = ($urandom_range(0, 99) < 20) ? $urandom_range(1, CAL_N - 1) : 0;
        queue_key(jsct_pkg::KEY_CAL);
        for (int i = 0; i < restart_at; i++)
            queue_random_sample();
        if (restart_at != 0)
            queue_key(jsct_pkg::KEY_CAL);
        for (int i = 0; i < CAL_N; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                queue_key(pick_trim_key());
            case (style)
                0:  queue_sample(near_raw(120, 120), near_raw(2048, 250),
                                 near_raw(2048, 250), near_raw(2048, 250));
                1:  queue_sample(fixed_raw, fixed_raw, fixed_raw, fixed_raw);
                2:  queue_sample(near_raw(3500, 600), near_raw(600, 600),
                                 near_raw(3500, 600), near_raw(600, 600));
                default: queue_random_sample();
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the head of the send queue, holds it until accepted,
    // and inserts idle bursts. Prediction happens at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic                take;
        bit                  calm;
        jsct_pkg::out_item_t lv;
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
            send_gap <= 0;
        end
        else
        begin
            take = push && !full;
            if (take)
            begin
                if (apply_stick_item(items_to_send[0].data, lv))
                    stick_levels_due.push_back(lv);
                void'(items_to_send.pop_front());
                items_sent <= items_sent + 1;
                // Every hundred items the idle density changes, so that runs
                // without any gap alternate with busier stretches.
                if (items_sent % 100 == 0)
                    send_idle_pct <= 15 * $urandom_range(0, 2);
            end
            calm = items_to_send.size() < CALM_ITEMS;
            if (push && !take)
            begin
                // The offered item stays on the port until it is taken.
            end
            else if (send_gap > 0 && !calm)
            begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end
            else if (items_to_send.size() == 0 ||
                     (items_to_send[0].drain_first && stick_levels_due.size() != 0))
            begin
                push <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < send_idle_pct)
            begin
                send_gap <= $urandom_range(0, 11);
                push <= 1'b0;
            end
            else
            begin
                push <= 1'b1;
                item <= items_to_send[0].data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes results off the block with random stalls and checks
    // every field against the oldest expected stick level set.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        jsct_pkg::out_item_t want;
        bit                  calm;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (stick_levels_due.size() == 0)
                begin
                    report_mismatch("result with nothing expected", result.throttle_out, -1);
                end
                else
                begin
                    want = stick_levels_due.pop_front();
                    if (result.throttle_out !== want.throttle_out)
                        report_mismatch("throttle_out", result.throttle_out, want.throttle_out);
                    if (result.yaw_out !== want.yaw_out)
                        report_mismatch("yaw_out", result.yaw_out, want.yaw_out);
                    if (result.pitch_out !== want.pitch_out)
                        report_mismatch("pitch_out", result.pitch_out, want.pitch_out);
                    if (result.roll_out !== want.roll_out)
                        report_mismatch("roll_out", result.roll_out, want.roll_out);
                    if (result.fixed_height !== want.fixed_height)
                        report_mismatch("fixed_height", result.fixed_height, want.fixed_height);
                    if (result.power_down !== want.power_down)
                        report_mismatch("power_down", result.power_down, want.power_down);
                    results_checked++;
                    if (results_checked % 50 == 0)
                        pop_idle_pct <= 15 * $urandom_range(0, 2);
                end
            end
            calm = items_to_send.size() < CALM_ITEMS;
            if (pop_gap > 0 && !calm)
            begin
                pop_gap <= pop_gap - 1;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < pop_idle_pct)
            begin
                pop_gap <= $urandom_range(0, 11);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
                timed_out <= 1'b1;
        end
    end

    initial
    begin
        int pick;
        int burst;
        jsct_pkg::key_t k;

        // Directed part: converter extremes, mid scale, every key but calibrate, trims at
        // the clamp edges, and a pause until every result has drained.
        queue_sample(12'd0, 12'd0, 12'd0, 12'd0);
        queue_sample(12'(RAW_MAX), 12'(RAW_MAX), 12'(RAW_MAX), 12'(RAW_MAX));
        queue_sample(12'd2048, 12'd2047, 12'd1, 12'd4094);
        queue_key(jsct_pkg::KEY_NONE, 1'b1);
        queue_sample(12'hAAA, 12'h555, 12'hF0F, 12'h0F0);
        queue_key(jsct_pkg::KEY_ROLL_INC);
        queue_key(jsct_pkg::KEY_PITCH_INC);
        queue_sample(12'd0, 12'd0, 12'd0, 12'd0);
        queue_sample(12'(RAW_MAX), 12'(RAW_MAX), 12'(RAW_MAX), 12'(RAW_MAX));
        queue_key(jsct_pkg::KEY_ROLL_DEC);
        queue_key(jsct_pkg::KEY_ROLL_DEC);
        queue_key(jsct_pkg::KEY_PITCH_DEC);
        queue_key(jsct_pkg::KEY_PITCH_DEC);
        queue_sample(12'd0, 12'd0, 12'd0, 12'd0);
        queue_sample(12'(RAW_MAX), 12'(RAW_MAX), 12'(RAW_MAX), 12'(RAW_MAX));
        queue_key(jsct_pkg::KEY_FIX);
        queue_sample(12'd1000, 12'd3000, 12'd2000, 12'd4000);
        queue_key(jsct_pkg::KEY_PWR);
        queue_sample(12'd4000, 12'd100, 12'd3000, 12'd50, 1'b1);
        queue_key(jsct_pkg::KEY_FIX);

        // Random part: mostly stick runs and complete calibrations with
        // random content, plus trim bursts long enough to saturate, flag
        // keys, and some items with every field random.
        while (items_to_send.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                burst = $urandom_range(5, 30);
                for (int i = 0; i < burst; i++)
                    queue_random_sample();
            end
            else if (pick < 55)
            begin
                queue_calibration();
            end
            else if (pick < 67)
            begin
                k = pick_trim_key();
                burst = ($urandom_range(0, 99) < 30) ? $urandom_range(101, 120)
                                                     : $urandom_range(1, 20);
                for (int i = 0; i < burst; i++)
                    queue_key(k);
                for (int i = 0; i < 3; i++)
                    queue_random_sample();
            end
            else if (pick < 77)
            begin
                case ($urandom_range(0, 2))
                    0:       queue_key(jsct_pkg::KEY_FIX);
                    1:       queue_key(jsct_pkg::KEY_PWR);
                    default: queue_key(jsct_pkg::KEY_NONE);
                endcase
                queue_random_sample();
            end
            else if (pick < 82)
            begin
                queue_sample(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 1'b1);
            end
            else
            begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst; i++)
                begin
                    if ($urandom_range(0, 1))
                        queue_key(jsct_pkg::key_t'($urandom_range(0, 7)));
                    else
                        queue_random_sample();
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                while (items_to_send.size() != 0 || stick_levels_due.size() != 0)
                    @(posedge clk);
                repeat (TAIL_CYCLES) @(posedge clk);
            end
            begin
                while (!timed_out)
                    @(posedge clk);
            end
        join_any
        disable fork;

        if (timed_out)
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        if (stick_levels_due.size() != 0)
            report_mismatch("results never delivered", 0, stick_levels_due.size());

        $display("Sent %0d items and checked %0d stick results with %0d mismatches.",
                 items_sent, results_checked, mismatches);
        $display("Completed %0d calibrations; %0d trim presses hit the bias limit.",
                 calibrations_done, trims_saturated);
        if (!timed_out && mismatches == 0)
            $display("tb_joystick_scale_calibrate_trim_top: PASS");
        else
            $display("tb_joystick_scale_calibrate_trim_top: FAIL");
        $finish;
    end

endmodule
